>>> design/odo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// Widths and constants shared by the odometry block and its rotation unit.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int IN_COUNT_W = 16;
  localparam int POSE_W     = 32;
  localparam int ANGLE_W    = 32;
  localparam int REG_W      = 32;
  localparam int TRIG_W     = 33;
  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = 5;

  typedef enum logic {OP_UPDATE = 1'b0, OP_CLEAR = 1'b1} req_op_t;
  typedef enum logic {
    REG_DIST_PER_TICK       = 1'b0,
    REG_ANGLE_PER_TICK_DIFF = 1'b1
  } reg_index_t;

  localparam logic signed [TRIG_W-1:0] CORDIC_START = 33'sd652032874;

  localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

>>> design/odo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_if
// Handshake channels for encoder samples in and pose results out.
// ----------------------------------------------------------------------------
interface odo_sample_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] right_count;
  logic signed [15:0] left_count;

  modport source (output valid, output op, output right_count, output left_count,
                  input ready);
  modport sink (input valid, input op, input right_count, input left_count,
                output ready);
endinterface

interface odo_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                output ready);
endinterface

>>> design/odo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module odo_cordic #(
  parameter int STEPS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [odo_pkg::ANGLE_W-1:0]        angle,
  output logic                               done,
  output logic signed [odo_pkg::TRIG_W-1:0]  cos_val,
  output logic signed [odo_pkg::TRIG_W-1:0]  sin_val
);
  import odo_pkg::*;

  localparam logic [ATAN_IDX_W-1:0] LAST_IDX = ATAN_IDX_W'(STEPS - 1);

  logic                      running;
  logic                      flip;
  logic [ATAN_IDX_W-1:0]     idx;
  logic signed [TRIG_W-1:0]  x;
  logic signed [TRIG_W-1:0]  y;
  logic signed [TRIG_W-1:0]  z;
  logic signed [TRIG_W-1:0]  xs;
  logic signed [TRIG_W-1:0]  ys;
  logic signed [TRIG_W-1:0]  at;
  logic                      flip_next;
  logic [ANGLE_W-1:0]        ang_f;

  assign flip_next = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign ang_f     = {angle[ANGLE_W-1] ^ flip_next, angle[ANGLE_W-2:0]};
  assign xs        = x >>> idx;
  assign ys        = y >>> idx;
  assign at        = signed'({1'b0, ATAN_TAB[idx]});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      idx     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        idx     <= '0;
        flip    <= flip_next;
        x       <= CORDIC_START;
        y       <= '0;
        z       <= TRIG_W'(signed'(ang_f));
      end else if (running) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (idx == LAST_IDX) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign cos_val = flip ? -x : x;
  assign sin_val = flip ? -y : y;

endmodule

>>> design/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose from two absolute wheel encoder counts.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                          | Handshake
//  sample   | in  | op, right_count, left_count      | valid / ready
//  pose     | out | pos_x, pos_y, heading            | valid / ready
//  cfg      | in  | cfg_index, cfg_data              | cfg_we, no wait
//
// An update request passes through the heading, magnitude, rotation, X and Y
// states before its result; a clear request goes straight to the output state.
// The time is set by the CORDIC iterations and six passes through one multiplier.
// Reset clears the pose and the stored counts and loads the register defaults.
// A new request is taken while the previous result waits on the pose channel;
// the block stalls only if that result is still not taken when the next is done.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int COUNT_WIDTH  = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [odo_pkg::REG_W-1:0]  cfg_data,
  odo_sample_if.sink                 sample,
  odo_pose_if.source                 pose
);
  import odo_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int MAG_W = CW + 1;
  localparam int M_W   = CW + 16;
  localparam int R_W   = M_W + 1;
  localparam int S_W   = R_W + 2;
  localparam int MA_W  = 33;
  localparam int MB_W  = 32;
  localparam int P_W   = MA_W + MB_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HEAD = 4'd1;
  localparam logic [3:0] S_MAG  = 4'd2;
  localparam logic [3:0] S_ROT  = 4'd3;
  localparam logic [3:0] S_XLO  = 4'd4;
  localparam logic [3:0] S_XHI  = 4'd5;
  localparam logic [3:0] S_XADD = 4'd6;
  localparam logic [3:0] S_YLO  = 4'd7;
  localparam logic [3:0] S_YHI  = 4'd8;
  localparam logic [3:0] S_YADD = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic signed [S_W-1:0] POS_MAX = S_W'(64'sh7FFF_FFFF);
  localparam logic signed [S_W-1:0] POS_MIN = -S_W'(64'sh8000_0000);

  logic [3:0]                state;
  logic [REG_W-1:0]          dist_per_tick;
  logic [REG_W-1:0]          angle_per_tick_diff;
  logic signed [CW-1:0]      last_right;
  logic signed [CW-1:0]      last_left;
  logic signed [POSE_W-1:0]  x_acc;
  logic signed [POSE_W-1:0]  y_acc;
  logic [ANGLE_W-1:0]        heading_acc;
  logic signed [MAG_W-1:0]   diff;
  logic [MAG_W-1:0]          mag;
  logic                      sum_neg;
  logic [M_W-1:0]            m;
  logic [R_W-1:0]            racc;

  logic signed [CW-1:0]      r_lat;
  logic signed [CW-1:0]      l_lat;
  logic signed [CW-1:0]      dr;
  logic signed [CW-1:0]      dl;
  logic signed [MAG_W-1:0]   sum_w;
  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [P_W-1:0]            prod;
  logic                      rot_start;
  logic                      rot_done;
  logic signed [TRIG_W-1:0]  cos_val;
  logic signed [TRIG_W-1:0]  sin_val;
  logic signed [TRIG_W-1:0]  trig;
  logic [MB_W-1:0]           trig_abs;
  logic                      neg;
  logic signed [S_W-1:0]     pos_cur;
  logic signed [S_W-1:0]     pos_sum;
  logic signed [POSE_W-1:0]  pos_sat;
  logic [63:0]               m_ext;
  logic                      take;
  logic                      out_free;

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (rot_start),
    .angle   (heading_acc),
    .done    (rot_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  assign sample.ready = (state == S_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_free     = !pose.valid || pose.ready;
  assign rot_start    = (state == S_MAG);

  assign r_lat = CW'(sample.right_count);
  assign l_lat = CW'(sample.left_count);
  assign dr    = r_lat - last_right;
  assign dl    = l_lat - last_left;
  assign sum_w = MAG_W'(dr) + MAG_W'(dl);
  assign m_ext = 64'(m);

  always_comb begin
    if (state == S_XLO || state == S_XHI || state == S_XADD) begin
      trig = cos_val;
    end else begin
      trig = sin_val;
    end
    trig_abs = MB_W'(trig[TRIG_W-1] ? -trig : trig);
    neg      = sum_neg ^ trig[TRIG_W-1];
  end

  always_comb begin
    unique case (state)
      S_HEAD: begin
        mul_a = {1'b0, 32'(diff)};
        mul_b = angle_per_tick_diff;
      end
      S_MAG: begin
        mul_a = MA_W'(mag);
        mul_b = dist_per_tick;
      end
      S_XLO, S_YLO: begin
        mul_a = MA_W'(m_ext[31:0]);
        mul_b = trig_abs;
      end
      S_XHI, S_YHI: begin
        mul_a = MA_W'(m_ext[63:32]);
        mul_b = trig_abs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = P_W'(mul_a) * P_W'(mul_b);
  end

  always_comb begin
    if (state == S_XADD) begin
      pos_cur = S_W'(x_acc);
    end else begin
      pos_cur = S_W'(y_acc);
    end
    if (neg) begin
      pos_sum = pos_cur - signed'(S_W'(racc));
    end else begin
      pos_sum = pos_cur + signed'(S_W'(racc));
    end
    if (pos_sum > POS_MAX) begin
      pos_sat = POSE_W'(POS_MAX);
    end else if (pos_sum < POS_MIN) begin
      pos_sat = POSE_W'(POS_MIN);
    end else begin
      pos_sat = POSE_W'(pos_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      dist_per_tick       <= 32'd429497;
      angle_per_tick_diff <= 32'd1193046;
      last_right          <= '0;
      last_left           <= '0;
      x_acc               <= '0;
      y_acc               <= '0;
      heading_acc         <= '0;
      pose.valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIST_PER_TICK:       dist_per_tick       <= cfg_data;
          REG_ANGLE_PER_TICK_DIFF: angle_per_tick_diff <= cfg_data;
          default:   ;
        endcase
      end
      if (pose.valid && pose.ready && (state != S_OUT)) begin
        pose.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            last_right <= r_lat;
            last_left  <= l_lat;
            if (sample.op == OP_CLEAR) begin
              x_acc       <= '0;
              y_acc       <= '0;
              heading_acc <= '0;
              state       <= S_OUT;
            end else begin
              diff    <= MAG_W'(dr) - MAG_W'(dl);
              sum_neg <= sum_w[MAG_W-1];
              mag     <= sum_w[MAG_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
              state   <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          heading_acc <= heading_acc + prod[ANGLE_W-1:0];
          state       <= S_MAG;
        end
        S_MAG: begin
          m     <= M_W'(prod >> 17);
          state <= S_ROT;
        end
        S_ROT: begin
          if (rot_done) begin
            state <= S_XLO;
          end
        end
        S_XLO, S_YLO: begin
          racc  <= R_W'(prod >> 30);
          state <= (state == S_XLO) ? S_XHI : S_YHI;
        end
        S_XHI, S_YHI: begin
          racc  <= racc + R_W'(prod << 2);
          state <= (state == S_XHI) ? S_XADD : S_YADD;
        end
        S_XADD: begin
          x_acc <= pos_sat;
          state <= S_YLO;
        end
        S_YADD: begin
          y_acc <= pos_sat;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            pose.valid   <= 1'b1;
            pose.pos_x   <= x_acc;
            pose.pos_y   <= y_acc;
            pose.heading <= heading_acc;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
